>>> rtl/aup_pkg.sv
// Package for the aaa URI field parser: payload types, phase codes, characters and keyword tables.
`timescale 1ns / 1ps

package aup_pkg;

    localparam int MAX_URI_LEN = 1024;
    // Position counter saturates at MAX_URI_LEN + 1
    localparam int POS_W = $clog2(MAX_URI_LEN + 2);

    localparam int NUM_SLOTS   = 10;
    localparam int SLOT_HOST   = 0;
    localparam int SLOT_PORT   = 2;
    localparam int SLOT_PARAMS = 4;
    localparam int SLOT_TRANS  = 6;
    localparam int SLOT_PROTO  = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_PREF  = 3'd2;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_T_LOWER = 8'h74;
    localparam logic [7:0] CH_T_UPPER = 8'h54;
    localparam logic [7:0] CH_P_LOWER = 8'h70;
    localparam logic [7:0] CH_P_UPPER = 8'h50;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [3:0] KW_TRANS_LEN = 4'd9;
    localparam logic [3:0] KW_PROTO_LEN = 4'd8;

    localparam int PREFIX_LEN = 6;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_INIT,
        PH_HOST,
        PH_PORT,
        PH_PARAM,
        PH_EAT,
        PH_MATCH,
        PH_VAL
    } phase_t;

    typedef struct packed {
        logic [7:0] uri_byte;
        logic       last_byte;
    } uri_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  host_start;
        logic [10:0] host_len;
        logic [9:0]  port_start;
        logic [10:0] port_len;
        logic [15:0] port_number;
        logic [9:0]  params_start;
        logic [10:0] params_len;
        logic [9:0]  transport_start;
        logic [10:0] transport_len;
        logic [9:0]  protocol_start;
        logic [10:0] protocol_len;
    } uri_out_t;

    // Fold A-Z to lower case
    function automatic logic [7:0] fold_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b | CASE_BIT;
        end
        return r;
    endfunction

    // Keyword characters after the leading t or p; kind 0 is transport, 1 is protocol
    function automatic logic [7:0] kw_char(input logic kind, input logic [3:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (!kind)
        begin
            case (idx)
                4'd0:    r = 8'h72; // r
                4'd1:    r = 8'h61; // a
                4'd2:    r = 8'h6E; // n
                4'd3:    r = 8'h73; // s
                4'd4:    r = 8'h70; // p
                4'd5:    r = 8'h6F; // o
                4'd6:    r = 8'h72; // r
                4'd7:    r = 8'h74; // t
                4'd8:    r = 8'h3D; // =
                default: r = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    r = 8'h72; // r
                4'd1:    r = 8'h6F; // o
                4'd2:    r = 8'h74; // t
                4'd3:    r = 8'h6F; // o
                4'd4:    r = 8'h63; // c
                4'd5:    r = 8'h6F; // o
                4'd6:    r = 8'h6C; // l
                4'd7:    r = 8'h3D; // =
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

>>> rtl/aaa_uri_field_parser_top.sv
// Streaming parser for aaa:// URIs, one byte per cycle unless stalled, one result per URI.
//
// Input channel byte_valid / byte_stall / byte_data carries one URI byte per
// transfer, with last_byte set on the final byte. The block accepts a byte
// in every cycle unless a result is held and the receiver stalls.
// Output channel res_valid / res_stall / res_data carries one result per URI:
// status plus start and length of host, port, params, transport and protocol,
// and the port number. The result appears in the cycle after the transfer of
// the last byte; throughput is one byte per cycle while byte_stall is low,
// set by the single register stage holding the parse state.
// While res_stall holds a waiting result, byte_stall rises; when the result
// is taken in a cycle, a new byte may be accepted in that same cycle.
// After the last byte all parse state returns to its reset values.
// Reset (rst_n low) clears the parse state and drops any held result.
`timescale 1ns / 1ps

module aaa_uri_field_parser_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  aup_pkg::uri_in_t  byte_data,
    output logic            res_valid,
    input  logic            res_stall,
    output aup_pkg::uri_out_t res_data
);

    localparam int PW = aup_pkg::POS_W;
    localparam logic [PW-1:0] MAX_POS = PW'(aup_pkg::MAX_URI_LEN);

    aup_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   seg_reg, seg_next;
    logic [PW-1:0]   val_reg, val_next;
    logic            kind_reg, kind_next;
    logic [3:0]      kidx_reg, kidx_next;
    logic [15:0]     port_reg, port_next;
    logic [2:0]      err_reg, err_next;
    logic [PW-1:0]   offs_reg [aup_pkg::NUM_SLOTS];
    logic [PW-1:0]   offs_next [aup_pkg::NUM_SLOTS];

    logic              res_valid_reg;
    aup_pkg::uri_out_t res_data_reg, res_data_next;

    logic accept;

    assign byte_stall = res_valid_reg && res_stall;
    assign accept     = byte_valid && !byte_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    // Parse step for the incoming byte
    always_comb
    begin
        logic [7:0]  b;
        logic        ok;
        logic [3:0]  klen;
        logic [3:0]  kidx_inc;
        logic [15:0] acc;
        b        = byte_data.uri_byte;
        ok       = 1'b1;
        klen     = kind_reg ? aup_pkg::KW_PROTO_LEN : aup_pkg::KW_TRANS_LEN;
        kidx_inc = kidx_reg + 4'd1;
        acc      = (port_reg << 3) + (port_reg << 1) + {8'h00, b - aup_pkg::CH_ZERO};

        phase_next = phase_reg;
        seg_next   = seg_reg;
        val_next   = val_reg;
        kind_next  = kind_reg;
        kidx_next  = kidx_reg;
        port_next  = port_reg;
        err_next   = err_reg;
        offs_next  = offs_reg;

        if (err_reg == aup_pkg::ST_OK && pos_reg < MAX_POS)
        begin
            case (phase_reg)
                aup_pkg::PH_PREFIX:
                begin
                    if (pos_reg < PW'(3))
                    begin
                        ok = (b | aup_pkg::CASE_BIT) == aup_pkg::CH_A_LOWER;
                    end
                    else if (pos_reg == PW'(3))
                    begin
                        ok = b == aup_pkg::CH_COLON;
                    end
                    else
                    begin
                        ok = b == aup_pkg::CH_SLASH;
                    end
                    if (!ok)
                    begin
                        err_next = aup_pkg::ST_BAD_PREF;
                    end
                    if (pos_reg >= PW'(5))
                    begin
                        phase_next = aup_pkg::PH_INIT;
                    end
                end
                aup_pkg::PH_INIT:
                begin
                    seg_next   = pos_reg;
                    phase_next = aup_pkg::PH_HOST;
                end
                aup_pkg::PH_HOST:
                begin
                    if (b == aup_pkg::CH_COLON)
                    begin
                        offs_next[aup_pkg::SLOT_HOST]     = seg_reg;
                        offs_next[aup_pkg::SLOT_HOST + 1] = pos_reg - seg_reg;
                        seg_next   = pos_reg + PW'(1);
                        port_next  = 16'h0000;
                        phase_next = aup_pkg::PH_PORT;
                    end
                    else if (b == aup_pkg::CH_SEMI)
                    begin
                        offs_next[aup_pkg::SLOT_HOST]     = seg_reg;
                        offs_next[aup_pkg::SLOT_HOST + 1] = pos_reg - seg_reg;
                        seg_next   = pos_reg + PW'(1);
                        phase_next = aup_pkg::PH_PARAM;
                    end
                    else if (b == aup_pkg::CH_AMP || b == aup_pkg::CH_AT ||
                             b == aup_pkg::CH_QUEST)
                    begin
                        err_next = aup_pkg::ST_BAD_CHAR;
                    end
                end
                aup_pkg::PH_PORT:
                begin
                    if (b == aup_pkg::CH_SEMI)
                    begin
                        offs_next[aup_pkg::SLOT_PORT]     = seg_reg;
                        offs_next[aup_pkg::SLOT_PORT + 1] = pos_reg - seg_reg;
                        seg_next   = pos_reg + PW'(1);
                        phase_next = aup_pkg::PH_PARAM;
                    end
                    else if (b >= aup_pkg::CH_ZERO && b <= aup_pkg::CH_NINE)
                    begin
                        port_next = acc;
                    end
                    else
                    begin
                        err_next = aup_pkg::ST_BAD_CHAR;
                    end
                end
                aup_pkg::PH_PARAM:
                begin
                    if (b == aup_pkg::CH_T_LOWER || b == aup_pkg::CH_T_UPPER)
                    begin
                        kind_next  = 1'b0;
                        kidx_next  = 4'd0;
                        phase_next = aup_pkg::PH_MATCH;
                    end
                    else if (b == aup_pkg::CH_P_LOWER || b == aup_pkg::CH_P_UPPER)
                    begin
                        kind_next  = 1'b1;
                        kidx_next  = 4'd0;
                        phase_next = aup_pkg::PH_MATCH;
                    end
                end
                aup_pkg::PH_MATCH:
                begin
                    if (kidx_reg >= klen)
                    begin
                        phase_next = aup_pkg::PH_EAT;
                    end
                    else if (aup_pkg::fold_lower(b) == aup_pkg::kw_char(kind_reg, kidx_reg))
                    begin
                        kidx_next = kidx_inc;
                        if (kidx_inc == klen)
                        begin
                            val_next   = pos_reg + PW'(1);
                            phase_next = aup_pkg::PH_VAL;
                        end
                    end
                    else
                    begin
                        phase_next = (b == aup_pkg::CH_SEMI) ? aup_pkg::PH_PARAM
                                                             : aup_pkg::PH_EAT;
                    end
                end
                aup_pkg::PH_EAT:
                begin
                    if (b == aup_pkg::CH_SEMI)
                    begin
                        phase_next = aup_pkg::PH_PARAM;
                    end
                end
                aup_pkg::PH_VAL:
                begin
                    if (b == aup_pkg::CH_SEMI)
                    begin
                        if (kind_reg)
                        begin
                            offs_next[aup_pkg::SLOT_PROTO]     = val_reg;
                            offs_next[aup_pkg::SLOT_PROTO + 1] = pos_reg - val_reg;
                        end
                        else
                        begin
                            offs_next[aup_pkg::SLOT_TRANS]     = val_reg;
                            offs_next[aup_pkg::SLOT_TRANS + 1] = pos_reg - val_reg;
                        end
                        phase_next = aup_pkg::PH_PARAM;
                    end
                end
                default:
                begin
                    phase_next = aup_pkg::PH_PARAM;
                end
            endcase
        end

        // Saturate one past the limit
        pos_next = (pos_reg <= MAX_POS) ? pos_reg + PW'(1) : pos_reg;
    end

    // Close open fields at the end of the URI and build the result
    always_comb
    begin
        logic [PW-1:0] len;
        logic [2:0]    status;
        logic [PW-1:0] fin [aup_pkg::NUM_SLOTS];
        len    = pos_reg + PW'(1);
        status = aup_pkg::ST_OK;
        fin    = offs_next;

        if (len < PW'(aup_pkg::PREFIX_LEN))
        begin
            status = aup_pkg::ST_TOO_SHORT;
        end
        else if (len > MAX_POS)
        begin
            status = aup_pkg::ST_TOO_LONG;
        end
        else if (err_next != aup_pkg::ST_OK)
        begin
            status = err_next;
        end
        else
        begin
            case (phase_next)
                aup_pkg::PH_HOST:
                begin
                    fin[aup_pkg::SLOT_HOST]     = seg_next;
                    fin[aup_pkg::SLOT_HOST + 1] = len - seg_next;
                end
                aup_pkg::PH_PORT:
                begin
                    fin[aup_pkg::SLOT_PORT]     = seg_next;
                    fin[aup_pkg::SLOT_PORT + 1] = len - seg_next;
                end
                aup_pkg::PH_VAL:
                begin
                    if (kind_next)
                    begin
                        fin[aup_pkg::SLOT_PROTO]     = val_next;
                        fin[aup_pkg::SLOT_PROTO + 1] = len - val_next;
                    end
                    else
                    begin
                        fin[aup_pkg::SLOT_TRANS]     = val_next;
                        fin[aup_pkg::SLOT_TRANS + 1] = len - val_next;
                    end
                    fin[aup_pkg::SLOT_PARAMS]     = seg_next;
                    fin[aup_pkg::SLOT_PARAMS + 1] = len - seg_next;
                end
                aup_pkg::PH_PARAM,
                aup_pkg::PH_EAT,
                aup_pkg::PH_MATCH:
                begin
                    fin[aup_pkg::SLOT_PARAMS]     = seg_next;
                    fin[aup_pkg::SLOT_PARAMS + 1] = len - seg_next;
                end
                default:
                begin
                    status = aup_pkg::ST_TOO_SHORT;
                end
            endcase
        end

        res_data_next = '0;
        res_data_next.status = status;
        if (status == aup_pkg::ST_OK)
        begin
            // Drop the start of any absent field
            res_data_next.host_start = (fin[1] == '0) ? 10'd0 : fin[0][9:0];
            res_data_next.host_len   = fin[1][10:0];
            res_data_next.port_start = (fin[3] == '0) ? 10'd0 : fin[2][9:0];
            res_data_next.port_len   = fin[3][10:0];
            res_data_next.port_number = port_next;
            res_data_next.params_start = (fin[5] == '0) ? 10'd0 : fin[4][9:0];
            res_data_next.params_len   = fin[5][10:0];
            res_data_next.transport_start = (fin[7] == '0) ? 10'd0 : fin[6][9:0];
            res_data_next.transport_len   = fin[7][10:0];
            res_data_next.protocol_start = (fin[9] == '0) ? 10'd0 : fin[8][9:0];
            res_data_next.protocol_len   = fin[9][10:0];
        end
    end

    // Parse state: advance on each transfer, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aup_pkg::PH_PREFIX;
            pos_reg   <= '0;
            seg_reg   <= '0;
            val_reg   <= '0;
            kind_reg  <= 1'b0;
            kidx_reg  <= 4'd0;
            port_reg  <= 16'h0000;
            err_reg   <= aup_pkg::ST_OK;
            for (int i = 0; i < aup_pkg::NUM_SLOTS; i++)
            begin
                offs_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (byte_data.last_byte)
            begin
                phase_reg <= aup_pkg::PH_PREFIX;
                pos_reg   <= '0;
                seg_reg   <= '0;
                val_reg   <= '0;
                kind_reg  <= 1'b0;
                kidx_reg  <= 4'd0;
                port_reg  <= 16'h0000;
                err_reg   <= aup_pkg::ST_OK;
                for (int i = 0; i < aup_pkg::NUM_SLOTS; i++)
                begin
                    offs_reg[i] <= '0;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                seg_reg   <= seg_next;
                val_reg   <= val_next;
                kind_reg  <= kind_next;
                kidx_reg  <= kidx_next;
                port_reg  <= port_next;
                err_reg   <= err_next;
                for (int i = 0; i < aup_pkg::NUM_SLOTS; i++)
                begin
                    offs_reg[i] <= offs_next[i];
                end
            end
        end
    end

    // Result register: load on the last byte, release when transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && byte_data.last_byte)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_data.last_byte)
        begin
            res_data_reg <= res_data_next;
        end
    end

endmodule
